[design/bdc_pkg.sv]
// Shared types and constants for the button debounce / click / long-press block.
// No dependencies.
package bdc_pkg;

  // Press timer width; the timer saturates at all ones.
  localparam int HOLD_W = 16;
  // Width used when comparing the timer with the 16-bit threshold.
  localparam int CMP_W  = (HOLD_W > 16) ? HOLD_W : 16;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_COUNT   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS_TICKS = 1'd1;

  localparam logic [7:0]  DEBOUNCE_RESET = 8'd3;
  localparam logic [15:0] LONG_RESET     = 16'd80;

  // Pin levels, active low button.
  localparam logic LVL_PRESSED  = 1'b0;
  localparam logic LVL_RELEASED = 1'b1;

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_CLICK = 2'd1,
    EV_LONG  = 2'd2
  } key_event_t;

  typedef struct packed {
    logic [7:0]  debounce_count;
    logic [15:0] long_press_ticks;
  } cfg_t;

endpackage

[design/button_debounce_click_long_press_core.sv]
// Button debounce with click and long-press events: top level.
// A tick passes the input register, then the result register, before out_valid rises.
// Throughput: one tick per cycle; a result left waiting by a low out_ready stalls the input.
// The state update is a single pass of compares and adds.
// Reset: synchronous active-low; stable and previous level released, counters cleared,
// config back to debounce 3 and threshold 80. Depends on bdc_pkg, bdc_cfg_regs, bdc_event_core.
module button_debounce_click_long_press_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_pin_level,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [1:0]                     out_key_event,
  input  logic                           cfg_we,
  input  logic [bdc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bdc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import bdc_pkg::*;

  cfg_t       cfg;
  key_event_t ev;

  // input register
  logic in_vld_r;
  logic pin_r;
  // result register
  logic       out_vld_r;
  key_event_t ev_r;

  // a tick moves from the input register into the result register when
  // the result slot is empty or being drained this cycle
  logic advance;
  assign advance  = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || advance;

  bdc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // state advances exactly once per tick, on the transfer to the result register
  bdc_event_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (advance),
    .pin_level (pin_r),
    .cfg       (cfg),
    .key_event (ev)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) pin_r <= in_pin_level;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) ev_r <= ev;
  end

  assign out_valid     = out_vld_r;
  assign out_key_event = ev_r;

endmodule

[design/bdc_cfg_regs.sv]
// Configuration register file: debounce count and long-press threshold.
// Depends on bdc_pkg.
module bdc_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [bdc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bdc_pkg::CFG_DATA_W-1:0] cfg_data,
  output bdc_pkg::cfg_t                  cfg
);
  import bdc_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_count   <= DEBOUNCE_RESET;
      cfg_r.long_press_ticks <= LONG_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DEBOUNCE_COUNT:   cfg_r.debounce_count   <= cfg_data[7:0];
        REG_LONG_PRESS_TICKS: cfg_r.long_press_ticks <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

[design/bdc_event_core.sv]
// Debounce state, press timer and event decode for one tick per cycle in which step is high.
// Depends on bdc_pkg.
module bdc_event_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  logic                pin_level,
  input  bdc_pkg::cfg_t       cfg,
  output bdc_pkg::key_event_t key_event
);
  import bdc_pkg::*;

  logic              stable_r, stable_nxt;
  logic              prev_r, prev_nxt;
  logic [7:0]        match_r, match_nxt;
  logic [HOLD_W-1:0] held_r, held_nxt;
  logic              long_r, long_nxt;
  key_event_t        ev;

  logic [CMP_W-1:0] held_mid_x, held_nxt_x, thr_x;
  logic [HOLD_W-1:0] held_mid;
  logic              long_mid;

  always_comb begin
    stable_nxt = stable_r;
    prev_nxt   = prev_r;
    match_nxt  = match_r;
    held_mid   = held_r;
    long_mid   = long_r;
    ev         = EV_NONE;
    thr_x      = CMP_W'(cfg.long_press_ticks);
    held_mid_x = CMP_W'(held_r);

    if (pin_level == prev_r) begin
      if (match_r < cfg.debounce_count) begin
        match_nxt = match_r + 8'd1;
      end else if (stable_r != pin_level) begin
        stable_nxt = pin_level;
        if (pin_level == LVL_PRESSED) begin
          held_mid = '0;
          long_mid = 1'b0;
        end else if (!long_r && (held_r != '0) && (held_mid_x < thr_x)) begin
          ev = EV_CLICK;
        end
      end
    end else begin
      prev_nxt  = pin_level;
      match_nxt = '0;
    end

    // timer only runs while pressed; a click tick is always released
    held_nxt = held_mid;
    long_nxt = long_mid;
    if (stable_nxt == LVL_PRESSED) begin
      if (held_mid != {HOLD_W{1'b1}}) held_nxt = held_mid + HOLD_W'(1);
    end
    held_nxt_x = CMP_W'(held_nxt);
    if ((stable_nxt == LVL_PRESSED) && (held_nxt_x >= thr_x) && !long_mid) begin
      long_nxt = 1'b1;
      ev       = EV_LONG;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stable_r <= LVL_RELEASED;
      prev_r   <= LVL_RELEASED;
      match_r  <= '0;
      held_r   <= '0;
      long_r   <= 1'b0;
    end else if (step) begin
      stable_r <= stable_nxt;
      prev_r   <= prev_nxt;
      match_r  <= match_nxt;
      held_r   <= held_nxt;
      long_r   <= long_nxt;
    end
  end

  assign key_event = ev;

endmodule

[design/bdc_checker.sv]
// Port-level checks for the button debounce top level, attached by bind.
// Depends on bdc_pkg and button_debounce_click_long_press_core.
module bdc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_key_event
);
  import bdc_pkg::*;

  logic out_xact;
  logic out_evt;
  assign out_xact = out_valid && out_ready;
  assign out_evt  = out_xact && (out_key_event != EV_NONE);

  // code 3 never appears on a delivered result
  a_no_bad_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_key_event == EV_NONE || out_key_event == EV_CLICK ||
                   out_key_event == EV_LONG))
    else $error("bdc: invalid key event code");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_key_event))
    else $error("bdc: stalled result changed");

  // nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("bdc: result valid after reset");

  // two events can never be back-to-back transactions
  a_event_spacing: assert property (@(posedge clk) disable iff (!rst_n)
    out_evt |=> !out_evt)
    else $error("bdc: events in consecutive transactions");

  // a result needs a prior input; checked only while in_valid is low
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid && !in_valid ##1 !in_valid |=> !out_valid || in_ready)
    else $error("bdc: result without input");

endmodule

bind button_debounce_click_long_press_core bdc_checker u_bdc_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_key_event (out_key_event)
);
